// ===== hw/rtl/trps_pkg.sv =====
// trps_pkg: shared types and constants for the threshold run pixel sorter
// used by trps_front, trps_back, the top level and the checker
// no dependencies
package trps_pkg;

    localparam int PIX_W   = 16;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W  = 1;
    localparam int QCNT_W  = 2;

    localparam logic [PIX_W-1:0] SENS_RESET = 16'd16384;
    localparam logic [PIX_W:0]   ONE_Q16    = 17'h1_0000;

    typedef struct packed {
        logic [PIX_W-1:0] hue;
        logic [PIX_W-1:0] saturation;
        logic [PIX_W-1:0] lightness;
        logic             row_end;
    } t_pix_in;

    typedef struct packed {
        logic [PIX_W-1:0] hue_out;
        logic [PIX_W-1:0] saturation_out;
        logic [PIX_W-1:0] lightness_out;
        logic             row_done;
        logic             last;
    } t_pix_out;

    typedef struct packed {
        logic [PIX_W-1:0] hue;
        logic [PIX_W-1:0] saturation;
        logic [PIX_W-1:0] lightness;
    } t_pixel;

    typedef struct packed {
        t_pixel pix;
        logic   in_band;
        logic   row_end;
    } t_cmd;

endpackage

// ===== hw/rtl/trps_front.sv =====
// trps_front: sensitivity register, lightness band test and a short command queue
// depends on trps_pkg
module trps_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [15:0]       i_cfg_data,
    input  logic              i_valid,
    output logic              o_ready,
    input  trps_pkg::t_pix_in i_pix,
    output logic              o_cmd_valid,
    input  logic              i_cmd_ready,
    output trps_pkg::t_cmd    o_cmd
);

    logic [trps_pkg::PIX_W-1:0]  r_sens;
    trps_pkg::t_cmd              r_q [trps_pkg::QUEUE_DEPTH];
    logic [trps_pkg::QPTR_W-1:0] r_wr;
    logic [trps_pkg::QPTR_W-1:0] r_rd;
    logic [trps_pkg::QCNT_W-1:0] r_cnt;

    logic           push;
    logic           pop;
    logic           in_band;
    logic [16:0]    lit_x;
    logic [16:0]    sens_x;
    trps_pkg::t_cmd cmd_in;

    assign lit_x   = {1'b0, i_pix.lightness};
    assign sens_x  = {1'b0, r_sens};
    assign in_band = (lit_x > sens_x) && (lit_x < (trps_pkg::ONE_Q16 - sens_x));

    assign cmd_in.pix.hue        = i_pix.hue;
    assign cmd_in.pix.saturation = i_pix.saturation;
    assign cmd_in.pix.lightness  = i_pix.lightness;
    assign cmd_in.in_band        = in_band;
    assign cmd_in.row_end        = i_pix.row_end;

    assign o_ready     = (r_cnt != trps_pkg::QCNT_W'(trps_pkg::QUEUE_DEPTH));
    assign o_cmd_valid = (r_cnt != '0);
    assign o_cmd       = r_q[r_rd];

    assign push = i_valid && o_ready;
    assign pop  = o_cmd_valid && i_cmd_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sens <= trps_pkg::SENS_RESET;
            r_wr   <= '0;
            r_rd   <= '0;
            r_cnt  <= '0;
        end else begin
            if (i_cfg_we) begin
                r_sens <= i_cfg_data;
            end
            if (push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr] <= cmd_in;
        end
    end

endmodule

// ===== hw/rtl/trps_back.sv =====
// trps_back: stable insertion-sorted run cells, flush sequencer and output register
// depends on trps_pkg
module trps_back #(
    parameter int RUN_DEPTH = 63
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cmd_valid,
    output logic               o_cmd_ready,
    input  trps_pkg::t_cmd     i_cmd,
    output logic               o_valid,
    input  logic               i_ready,
    output trps_pkg::t_pix_out o_pix
);

    localparam int LEN_W = $clog2(RUN_DEPTH + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_FLUSH,
        S_PASS
    } t_state;

    t_state             r_state;
    logic [LEN_W-1:0]   r_len;
    trps_pkg::t_pixel   r_cell [RUN_DEPTH];
    trps_pkg::t_pixel   n_cell [RUN_DEPTH];
    trps_pkg::t_pixel   r_pend;
    logic               r_pend_row;
    logic               r_end_done;
    logic               r_end_last;
    logic               r_out_valid;
    trps_pkg::t_pix_out r_out;

    logic             gt [RUN_DEPTH];
    logic             take;
    logic             slot;
    logic             insert;
    logic             pop;
    logic             load;
    logic             len_one;

    assign o_cmd_ready = (r_state == S_IDLE);
    assign take        = o_cmd_ready && i_cmd_valid;
    assign insert      = take && i_cmd.in_band;
    assign slot        = !r_out_valid || i_ready;
    assign pop         = (r_state == S_FLUSH) && slot;
    assign load        = slot && ((r_state == S_FLUSH) || (r_state == S_PASS));
    assign len_one     = (r_len == LEN_W'(1));
    assign o_valid     = r_out_valid;
    assign o_pix       = r_out;

    // cells holding a larger key move up one place; equal keys stay ahead
    always_comb begin
        for (int i = 0; i < RUN_DEPTH; i++) begin
            gt[i] = (LEN_W'(i) < r_len) && (r_cell[i].lightness > i_cmd.pix.lightness);
        end
        for (int i = 0; i < RUN_DEPTH; i++) begin
            n_cell[i] = r_cell[i];
        end
        if (pop) begin
            for (int i = 0; i < RUN_DEPTH - 1; i++) begin
                n_cell[i] = r_cell[i + 1];
            end
        end else if (insert) begin
            if (gt[0] || (r_len == '0)) begin
                n_cell[0] = i_cmd.pix;
            end
            for (int i = 1; i < RUN_DEPTH; i++) begin
                if (gt[i - 1]) begin
                    n_cell[i] = r_cell[i - 1];
                end else if (gt[i] || (LEN_W'(i) == r_len)) begin
                    n_cell[i] = i_cmd.pix;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cell <= n_cell;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_len       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (take) begin
                        if (i_cmd.in_band) begin
                            r_len <= r_len + LEN_W'(1);
                            if (i_cmd.row_end || (r_len == LEN_W'(RUN_DEPTH - 1))) begin
                                r_end_done <= i_cmd.row_end;
                                r_end_last <= 1'b1;
                                r_state    <= S_FLUSH;
                            end
                        end else begin
                            r_pend     <= i_cmd.pix;
                            r_pend_row <= i_cmd.row_end;
                            r_end_done <= 1'b0;
                            r_end_last <= 1'b0;
                            r_state    <= (r_len == '0) ? S_PASS : S_FLUSH;
                        end
                    end
                end
                S_FLUSH: begin
                    if (slot) begin
                        r_out.hue_out        <= r_cell[0].hue;
                        r_out.saturation_out <= r_cell[0].saturation;
                        r_out.lightness_out  <= r_cell[0].lightness;
                        r_out.row_done       <= len_one && r_end_done;
                        r_out.last           <= len_one && r_end_last;
                        r_len                <= r_len - LEN_W'(1);
                        if (len_one) begin
                            r_state <= r_end_last ? S_IDLE : S_PASS;
                        end
                    end
                end
                S_PASS: begin
                    if (slot) begin
                        r_out.hue_out        <= r_pend.hue;
                        r_out.saturation_out <= r_pend.saturation;
                        r_out.lightness_out  <= r_pend.lightness;
                        r_out.row_done       <= r_pend_row;
                        r_out.last           <= 1'b1;
                        r_state              <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== hw/rtl/threshold_run_pixel_sorter_unit.sv =====
// threshold_run_pixel_sorter_unit: top level, front classifier and queue feeding the sort back end
// depends on trps_pkg, trps_front, trps_back
// throughput: the back end takes no new pixel while it emits a run or a passed pixel, and results
// leave one per cycle through the output register while the receiver is ready
// reset: synchronous, clears the queue, run length and output valid, sensitivity to 16384
module threshold_run_pixel_sorter_unit #(
    parameter int RUN_DEPTH = 63
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [15:0]        i_cfg_data,
    input  logic               i_valid,
    output logic               o_ready,
    input  trps_pkg::t_pix_in  i_pix,
    output logic               o_valid,
    input  logic               i_ready,
    output trps_pkg::t_pix_out o_pix
);

    logic           cmd_valid;
    logic           cmd_ready;
    trps_pkg::t_cmd cmd;

    trps_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_pix       (i_pix),
        .o_cmd_valid (cmd_valid),
        .i_cmd_ready (cmd_ready),
        .o_cmd       (cmd)
    );

    trps_back #(
        .RUN_DEPTH (RUN_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .o_cmd_ready (cmd_ready),
        .i_cmd       (cmd),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_pix       (o_pix)
    );

endmodule

// ===== hw/rtl/trps_checker.sv =====
// trps_checker: port-level assertions for the threshold run pixel sorter, bound to the top level
// depends on trps_pkg and threshold_run_pixel_sorter_unit
module trps_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_ready,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input trps_pkg::t_pix_out i_out_pix
);

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_pix))
        else $error("result changed while stalled");

    // row end always closes the results of its pixel
    a_row_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_pix.row_done |-> i_out_pix.last)
        else $error("row_done without last");

    a_reset_out: assert property (@(posedge i_clk)
        $rose(i_rst_n) |-> !i_out_valid)
        else $error("result valid right after reset");

    a_reset_in: assert property (@(posedge i_clk)
        $rose(i_rst_n) |-> i_in_ready)
        else $error("input not ready right after reset");

endmodule

bind threshold_run_pixel_sorter_unit trps_checker u_trps_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (o_ready),
    .i_out_valid (o_valid),
    .i_out_ready (i_ready),
    .i_out_pix   (o_pix)
);

// ===== verif/threshold_run_pixel_sorter_unit_test.sv =====
// threshold_run_pixel_sorter_unit_test: self-checking bench for the threshold run pixel sorter
// drives pixel transfers with random bursts, predicts the sorted runs and checks every output
// depends on trps_pkg and threshold_run_pixel_sorter_unit
module threshold_run_pixel_sorter_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RUN_DEPTH = 63;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_we = 1'b0;
    logic [15:0]        i_cfg_data = '0;
    logic               i_valid = 1'b0;
    logic               o_ready;
    trps_pkg::t_pix_in  i_pix = '0;
    logic               o_valid;
    logic               i_ready = 1'b0;
    trps_pkg::t_pix_out o_pix;

    trps_pkg::t_pix_in  pending_pix[$];
    trps_pkg::t_pixel   band_run[$];
    trps_pkg::t_pix_out sorted_pix_due[$];
    logic [15:0]        band_margin = trps_pkg::SENS_RESET;
    int                 mismatch_count = 0;

    bit          sender_idle_en = 1'b0;
    int          stall_pct = 0;
    int          hold_req = 0;
    int          hold_ack = 0;
    int          hold_left = 0;
    int          burst_left = 0;
    int          gap_left = 0;

    threshold_run_pixel_sorter_unit #(
        .RUN_DEPTH(RUN_DEPTH)
    ) dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_data(i_cfg_data),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_pix     (i_pix),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .o_pix     (o_pix)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    task automatic flag_mismatch(input string what);
        $display("mismatch at %0t: %s", $time, what);
        mismatch_count++;
    endtask

    function automatic trps_pkg::t_pix_out make_result(input trps_pkg::t_pixel px,
                                                       input logic done, input logic fin);
        trps_pkg::t_pix_out res;
        res.hue_out        = px.hue;
        res.saturation_out = px.saturation;
        res.lightness_out  = px.lightness;
        res.row_done       = done;
        res.last           = fin;
        return res;
    endfunction

    // stable ascending lightness order, equal keys keep arrival order
    task automatic flush_band_run(input logic done_at_end, input logic last_at_end);
        trps_pkg::t_pixel ordered[$];
        int               pos;
        foreach (band_run[i]) begin
            pos = ordered.size();
            while (pos > 0 && ordered[pos-1].lightness > band_run[i].lightness) pos--;
            ordered.insert(pos, band_run[i]);
        end
        foreach (ordered[i]) begin
            sorted_pix_due.insert(sorted_pix_due.size(), make_result(ordered[i],
                (i == ordered.size() - 1) && done_at_end,
                (i == ordered.size() - 1) && last_at_end));
        end
        band_run.delete();
    endtask

    task automatic predict_pixel(input trps_pkg::t_pix_in p);
        trps_pkg::t_pixel px;
        int unsigned      lit;
        int unsigned      margin;
        px.hue        = p.hue;
        px.saturation = p.saturation;
        px.lightness  = p.lightness;
        lit    = p.lightness;
        margin = band_margin;
        if (lit > margin && lit < 32'h1_0000 - margin) begin
            band_run.insert(band_run.size(), px);
            if (p.row_end || band_run.size() >= RUN_DEPTH) flush_band_run(p.row_end, 1'b1);
        end else begin
            flush_band_run(1'b0, 1'b0);
            sorted_pix_due.insert(sorted_pix_due.size(), make_result(px, p.row_end, 1'b1));
        end
    endtask

    // sender: bursts of random length, with random gaps when sender_idle_en is set
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) predict_pixel(i_pix);
            if (!i_valid || o_ready) begin
                if (gap_left > 0) begin
                    gap_left = gap_left - 1;
                    i_valid <= 1'b0;
                end else if (pending_pix.size() > 0) begin
                    i_pix   <= pending_pix.pop_front();
                    i_valid <= 1'b1;
                    if (burst_left <= 1) begin
                        burst_left = $urandom_range(1, 12);
                        if (sender_idle_en && $urandom_range(0, 2) != 0)
                            gap_left = $urandom_range(1, 5);
                    end else begin
                        burst_left = burst_left - 1;
                    end
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // receiver: random stalls plus an occasional long hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else if (hold_ack != hold_req) begin
            hold_ack  = hold_req;
            hold_left = 400;
            i_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left = hold_left - 1;
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    always @(posedge i_clk) begin
        trps_pkg::t_pix_out want;
        if (i_rst_n && o_valid && i_ready) begin
            if (sorted_pix_due.size() == 0) begin
                flag_mismatch($sformatf("transfer with nothing pending: %h", o_pix));
            end else begin
                want = sorted_pix_due.pop_front();
                if (o_pix.hue_out !== want.hue_out)
                    flag_mismatch($sformatf("hue_out %h, want %h", o_pix.hue_out, want.hue_out));
                if (o_pix.saturation_out !== want.saturation_out)
                    flag_mismatch($sformatf("saturation_out %h, want %h",
                                            o_pix.saturation_out, want.saturation_out));
                if (o_pix.lightness_out !== want.lightness_out)
                    flag_mismatch($sformatf("lightness_out %h, want %h",
                                            o_pix.lightness_out, want.lightness_out));
                if (o_pix.row_done !== want.row_done)
                    flag_mismatch($sformatf("row_done %b, want %b",
                                            o_pix.row_done, want.row_done));
                if (o_pix.last !== want.last)
                    flag_mismatch($sformatf("last %b, want %b", o_pix.last, want.last));
            end
        end
    end

    task automatic add_pixel(input logic [15:0] hue, input logic [15:0] sat,
                             input logic [15:0] lit, input logic row_end);
        trps_pkg::t_pix_in p;
        p.hue        = hue;
        p.saturation = sat;
        p.lightness  = lit;
        p.row_end    = row_end;
        pending_pix.insert(pending_pix.size(), p);
    endtask

    function automatic logic [15:0] random_lightness(input int in_pct);
        int unsigned lo;
        int unsigned hi;
        int          pick;
        lo   = int'(band_margin) + 1;
        hi   = 65535 - int'(band_margin);
        pick = $urandom_range(0, 99);
        if (lo <= hi && pick < in_pct) return 16'($urandom_range(lo, hi));
        if (pick < 90) begin
            if (band_margin == 0 || $urandom_range(0, 1) == 0)
                return 16'($urandom_range(0, band_margin));
            return 16'($urandom_range(65536 - int'(band_margin), 65535));
        end
        return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
    endfunction

    // rows of random length, with some noise on the row-end flag
    task automatic queue_rows(input int count, input int in_pct);
        int row_len;
        int k;
        logic re;
        k = 0;
        while (k < count) begin
            row_len = $urandom_range(3, 18);
            for (int j = 0; j < row_len && k < count; j++) begin
                re = (j == row_len - 1);
                if ($urandom_range(0, 9) == 0) re = 1'($urandom_range(0, 1));
                add_pixel(16'($urandom), 16'($urandom), random_lightness(in_pct), re);
                k++;
            end
        end
        add_pixel(16'($urandom), 16'($urandom), 16'h0000, 1'b1);
    endtask

    task automatic wait_idle();
        do @(negedge i_clk);
        while (pending_pix.size() != 0 || i_valid || sorted_pix_due.size() != 0);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_margin(input logic [15:0] value);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        band_margin = value;
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset margin, band is 16385 to 49151
        add_pixel(16'h0000, 16'h0000, 16'h0000, 1'b0);
        add_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
        add_pixel(16'h1234, 16'h5678, 16'd16384, 1'b0);
        add_pixel(16'hAAAA, 16'h5555, 16'd49151, 1'b0);
        add_pixel(16'h5555, 16'hAAAA, 16'd16385, 1'b0);
        add_pixel(16'h0F0F, 16'hF0F0, 16'd49152, 1'b0);
        add_pixel(16'h0001, 16'h0101, 16'd30000, 1'b0);
        add_pixel(16'h0002, 16'h0202, 16'd30000, 1'b0);
        add_pixel(16'h0003, 16'h0303, 16'd20000, 1'b0);
        add_pixel(16'h0004, 16'h0404, 16'd30000, 1'b0);
        add_pixel(16'h0005, 16'h0505, 16'd25000, 1'b1);
        add_pixel(16'h8001, 16'h7FFE, 16'd40000, 1'b0);
        add_pixel(16'h8002, 16'h7FFD, 16'd100, 1'b1);
        add_pixel(16'h8003, 16'h7FFC, 16'd60000, 1'b0);
        add_pixel(16'h8004, 16'h7FFB, 16'd17000, 1'b1);
        add_pixel(16'h8005, 16'h7FFA, 16'd20000, 1'b0);
        add_pixel(16'h8006, 16'h7FF9, 16'd0, 1'b1);
        wait_idle();

        write_margin(16'd0);
        sender_idle_en = 1'b1;
        stall_pct      = 50;
        queue_rows(20, 70);
        wait_idle();

        // full run with repeated keys while the output is held off
        write_margin(16'd1000);
        sender_idle_en = 1'b0;
        stall_pct      = 10;
        hold_req++;
        for (int k = 0; k < RUN_DEPTH + 20; k++)
            add_pixel(16'($urandom), 16'($urandom), 16'(2000 + $urandom_range(0, 7) * 1000),
                      k == RUN_DEPTH + 19);
        queue_rows(6, 70);
        wait_idle();

        write_margin(16'd65535);
        sender_idle_en = 1'b1;
        stall_pct      = 30;
        queue_rows(10, 70);
        wait_idle();

        write_margin(16'd32767);
        for (int k = 0; k < 10; k++)
            add_pixel(16'($urandom), 16'($urandom), 16'($urandom_range(32765, 32771)),
                      $urandom_range(0, 5) == 0);
        wait_idle();

        write_margin(16'd32768);
        stall_pct = 0;
        queue_rows(6, 70);
        wait_idle();

        write_margin(16'($urandom_range(1, 32767)));
        stall_pct = 40;
        queue_rows(20, 75);
        wait_idle();

        write_margin(16'($urandom_range(1, 20000)));
        sender_idle_en = 1'b0;
        stall_pct      = 20;
        queue_rows(20, 80);
        wait_idle();

        repeat (20) @(posedge i_clk);
        if (mismatch_count == 0 && sorted_pix_due.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
